// ===== rtl/bqf_pkg.sv =====
package bqf_pkg;

    localparam int CHANNELS       = 8;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 20;
    localparam int COEF_BITS      = 24;
    localparam int STATE_BITS     = 48;
    localparam int CHAN_BITS      = 3;
    localparam int CFG_IDX_BITS   = 3;

    localparam int ADDR_BITS       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_BITS       = COEF_BITS + SAMPLE_BITS;
    localparam int SUM_BITS        = ((PROD_BITS > STATE_BITS) ? PROD_BITS : STATE_BITS) + 2;
    localparam int STATE_PAIR_BITS = 2 * STATE_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_B0 = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_B1 = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_B2 = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_A1 = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] REG_A2 = CFG_IDX_BITS'(4);

    // unity gain in the coefficient format
    localparam logic signed [COEF_BITS-1:0] B0_RESET = COEF_BITS'(64'sd1 <<< COEF_FRAC_BITS);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LOAD = 8'b0000_0010,
        S_ACC  = 8'b0000_0100,
        S_RND  = 8'b0000_1000,
        S_FB1  = 8'b0001_0000,
        S_FB2  = 8'b0010_0000,
        S_WB   = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    typedef struct packed {
        state_t step;
        logic   z_valid;
    } dp_ctrl_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } coef_set_t;

endpackage

// ===== rtl/multichannel_biquad_filter_unit.sv =====
// Multichannel biquad filter, transposed direct form II, one section
// shared by all channels.
// Input channel: in_valid / in_stall carrying channel and sample_in.
// Output channel: out_valid / out_stall carrying channel_out and sample_out.
// Config channel: cfg_valid / cfg_ready, cfg_index selects b0, b1, b2, a1, a2
// (indexes 0 to 4, others ignored); cfg_ready is always high. Write only
// while no beat is in flight.
// Each beat steps through load, accumulate, round, two feedback steps,
// write-back and done before its result enters the output register, and
// no new beat is taken until the last one is through. The single multiplier
// forms the five products one per cycle around the state memory read and
// write-back. A channel with no state goes straight to the done step and
// returns zero, without writing the state memory.
// The output register frees the core: a result held by out_stall blocks
// only the next result from leaving, and the core stalls at its last step
// until the register frees up.
// Reset loads the coefficients with a pass-through filter and marks every
// channel's state as zero; no clearing pass is needed.
module multichannel_biquad_filter_unit import bqf_pkg::*; (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [CHAN_BITS-1:0]          channel,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [CHAN_BITS-1:0]          channel_out,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [COEF_BITS-1:0]          cfg_data
);

    state_t                        state_reg;
    state_t                        state_next;
    coef_set_t                     coef_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [CHAN_BITS-1:0]          chan_reg;
    logic [ADDR_BITS-1:0]          addr_reg;
    logic                          range_reg;
    logic [CHANNELS-1:0]           valid_reg;
    logic                          out_valid_reg;
    logic [CHAN_BITS-1:0]          channel_out_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;

    logic                          in_accept;
    logic                          in_range;
    logic                          out_free;
    logic                          ram_we;
    logic [STATE_PAIR_BITS-1:0]    state_rd;
    logic [STATE_PAIR_BITS-1:0]    state_wr;
    logic signed [SAMPLE_BITS-1:0] y;
    dp_ctrl_t                      ctrl;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign in_range  = (int'(channel) < CHANNELS);
    assign out_free  = !out_valid_reg || !out_stall;
    assign ram_we    = (state_reg == S_WB);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = in_range ? S_LOAD : S_DONE;
                end
            end
            S_LOAD: state_next = S_ACC;
            S_ACC:  state_next = S_RND;
            S_RND:  state_next = S_FB1;
            S_FB1:  state_next = S_FB2;
            S_FB2:  state_next = S_WB;
            S_WB:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            coef_reg.b0   <= B0_RESET;
            coef_reg.b1   <= '0;
            coef_reg.b2   <= '0;
            coef_reg.a1   <= '0;
            coef_reg.a2   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_B0:  coef_reg.b0 <= cfg_data;
                    REG_B1:  coef_reg.b1 <= cfg_data;
                    REG_B2:  coef_reg.b2 <= cfg_data;
                    REG_A1:  coef_reg.a1 <= cfg_data;
                    REG_A2:  coef_reg.a2 <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // beat payload and held result
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg     <= sample_in;
            chan_reg  <= channel;
            addr_reg  <= ADDR_BITS'(channel);
            range_reg <= in_range;
        end
        if (state_reg == S_DONE && out_free)
        begin
            channel_out_reg <= chan_reg;
            sample_out_reg  <= range_reg ? y : '0;
        end
    end

    assign ctrl.step    = state_reg;
    assign ctrl.z_valid = valid_reg[addr_reg];

    bqf_ram #(
        .WIDTH (STATE_PAIR_BITS),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (state_wr),
        .raddr (ADDR_BITS'(channel)),
        .rdata (state_rd)
    );

    bqf_mac u_mac (
        .clk      (clk),
        .ctrl     (ctrl),
        .coef     (coef_reg),
        .x        (x_reg),
        .state_rd (state_rd),
        .state_wr (state_wr),
        .y        (y)
    );

    assign out_valid   = out_valid_reg;
    assign channel_out = channel_out_reg;
    assign sample_out  = sample_out_reg;

`ifndef SYNTH
    a_wb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> range_reg)
        else $error("state write-back for a channel with no state");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the final step");

    a_valid_only_on_wb: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_WB) |=> $stable(valid_reg))
        else $error("state valid bits changed without a write-back");
`endif

endmodule

// ===== rtl/bqf_ram.sv =====
module bqf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bqf_mac.sv =====
module bqf_mac import bqf_pkg::*; (
    input  logic                               clk,
    input  dp_ctrl_t                           ctrl,
    input  coef_set_t                          coef,
    input  logic signed [SAMPLE_BITS-1:0]      x,
    input  logic        [STATE_PAIR_BITS-1:0]  state_rd,
    output logic        [STATE_PAIR_BITS-1:0]  state_wr,
    output logic signed [SAMPLE_BITS-1:0]      y
);

    localparam logic signed [SUM_BITS-1:0] HALF = SUM_BITS'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam logic signed [SUM_BITS-1:0] SMP_MAX =
        SUM_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_BITS-1:0] SMP_MIN = -SMP_MAX - SUM_BITS'(1);
    localparam logic signed [SUM_BITS-1:0] ST_MAX =
        SUM_BITS'((64'sd1 <<< (STATE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_BITS-1:0] ST_MIN = -ST_MAX - SUM_BITS'(1);

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SUM_BITS-1:0] v
    );
        logic signed [SUM_BITS-1:0] c;
        begin
            c = v;
            if (v > SMP_MAX)
            begin
                c = SMP_MAX;
            end
            else if (v < SMP_MIN)
            begin
                c = SMP_MIN;
            end
            return c[SAMPLE_BITS-1:0];
        end
    endfunction

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [SUM_BITS-1:0] v
    );
        logic signed [SUM_BITS-1:0] c;
        begin
            c = v;
            if (v > ST_MAX)
            begin
                c = ST_MAX;
            end
            else if (v < ST_MIN)
            begin
                c = ST_MIN;
            end
            return c[STATE_BITS-1:0];
        end
    endfunction

    logic signed [COEF_BITS-1:0]   mul_a;
    logic signed [SAMPLE_BITS-1:0] mul_b;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [STATE_BITS-1:0]  z1_reg;
    logic signed [STATE_BITS-1:0]  z2_reg;
    logic signed [SUM_BITS-1:0]    acc_reg;
    logic signed [SUM_BITS-1:0]    t1_reg;
    logic signed [PROD_BITS-1:0]   t2_reg;
    logic signed [STATE_BITS-1:0]  z1n_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [SUM_BITS-1:0]    prod_ext;
    logic signed [SUM_BITS-1:0]    rnd_sum;
    logic signed [SUM_BITS-1:0]    rnd_shift;

    // one shared multiplier, operands picked by the sequencer step
    always_comb
    begin
        unique case (ctrl.step)
            S_LOAD:
            begin
                mul_a = coef.b0;
                mul_b = x;
            end
            S_ACC:
            begin
                mul_a = coef.b1;
                mul_b = x;
            end
            S_RND:
            begin
                mul_a = coef.b2;
                mul_b = x;
            end
            S_FB1:
            begin
                mul_a = coef.a1;
                mul_b = y_reg;
            end
            S_FB2:
            begin
                mul_a = coef.a2;
                mul_b = y_reg;
            end
            default:
            begin
                mul_a = coef.b0;
                mul_b = x;
            end
        endcase
    end

    assign prod_ext  = SUM_BITS'(prod_reg);
    assign rnd_sum   = acc_reg + HALF;
    assign rnd_shift = rnd_sum >>> COEF_FRAC_BITS;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (ctrl.step)
            S_LOAD:
            begin
                // an entry never written since reset reads as zero
                z1_reg <= ctrl.z_valid ? state_rd[STATE_PAIR_BITS-1:STATE_BITS] : '0;
                z2_reg <= ctrl.z_valid ? state_rd[STATE_BITS-1:0] : '0;
            end
            S_ACC:
            begin
                acc_reg <= prod_ext + SUM_BITS'(z1_reg);
            end
            S_RND:
            begin
                y_reg  <= sat_sample(rnd_shift);
                t1_reg <= prod_ext + SUM_BITS'(z2_reg);
            end
            S_FB1:
            begin
                t2_reg <= prod_reg;
            end
            S_FB2:
            begin
                z1n_reg <= sat_state(t1_reg - prod_ext);
            end
            default:
            begin
            end
        endcase
    end

    assign state_wr = {z1n_reg, sat_state(SUM_BITS'(t2_reg) - prod_ext)};
    assign y        = y_reg;

endmodule
